FILE: hdl/ps2mct_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor tracker.
package ps2mct_pkg;

	localparam int COORD_BITS = 12;
	localparam int SIZE_BITS  = 13;
	localparam int CFG_IDX_BITS = 1;
	// width for signed position arithmetic and clamping
	localparam int WIDE_BITS = ((SIZE_BITS > COORD_BITS) ? SIZE_BITS : COORD_BITS) + 2;

	localparam logic [SIZE_BITS-1:0]  WIDTH_RESET  = SIZE_BITS'(640);
	localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET = SIZE_BITS'(480);
	localparam logic [COORD_BITS-1:0] START_POS    = COORD_BITS'(100);

	localparam int           SYNC_BIT      = 3;
	localparam logic [7:0]   OVERFLOW_MASK = 8'hC0;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

	// byte status codes
	localparam logic [1:0] ST_STORED  = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_APPLIED = 2'd2;
	localparam logic [1:0] ST_DISCARD = 2'd3;

	// packet position codes
	localparam logic [1:0] POS_HEADER = 2'd0;
	localparam logic [1:0] POS_DX     = 2'd1;
	localparam logic [1:0] POS_DY     = 2'd2;

	typedef struct packed {
		logic       from_aux_port;
		logic [7:0] data_byte;
	} in_req_t;

	typedef struct packed {
		logic [1:0]            byte_status;
		logic [COORD_BITS-1:0] cursor_x;
		logic [COORD_BITS-1:0] cursor_y;
		logic [2:0]            button_bits;
	} out_req_t;

endpackage

FILE: hdl/ps2_mouse_packet_cursor_tracker.sv
// Top level: PS/2 mouse packet assembly and clamped cursor tracking.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  in       | input     | in_valid / in_stall  | in_data  (aux flag, byte)
//  out      | output    | out_valid / out_stall| out_data (status, x, y, buttons)
//  cfg      | input     | cfg_wr_en            | cfg_index, cfg_data
//
// One request per cycle while the result is not stalled; an accepted request
// passes through the input register, then the result register.
// Reset gives width 640, height 480, cursor at 100,100, buttons clear.
// A stalled result holds the result register; the next byte then waits in
// the input register and in_stall rises until out_stall drops.
module ps2_mouse_packet_cursor_tracker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  ps2mct_pkg::in_req_t                     in_data,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output ps2mct_pkg::out_req_t                    out_data,
	input  logic                                    cfg_wr_en,
	input  logic [ps2mct_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [ps2mct_pkg::SIZE_BITS-1:0]        cfg_data
);

	localparam int CB = ps2mct_pkg::COORD_BITS;
	localparam int WB = ps2mct_pkg::WIDE_BITS;
	localparam int SB = ps2mct_pkg::SIZE_BITS;

	logic [SB-1:0]         width_q, height_q;
	logic                  in_valid_s1;
	ps2mct_pkg::in_req_t   in_data_s1;
	logic                  out_valid_q;
	ps2mct_pkg::out_req_t  out_data_q;

	logic [1:0]            pkt_pos_q;
	logic [7:0]            header_q, dx_q;
	logic [CB-1:0]         pos_x_q, pos_y_q;
	logic [2:0]            buttons_q;

	logic                  advance;
	logic [1:0]            pkt_pos_d;
	logic [7:0]            header_d, dx_d;
	logic [CB-1:0]         pos_x_d, pos_y_d;
	logic [2:0]            buttons_d;
	logic [1:0]            status_d;

	// add a signed delta and clamp to 0..size-1, capped at the coordinate maximum
	function automatic logic [CB-1:0] clamp_axis(
		input logic [CB-1:0]        pos,
		input logic signed [WB-1:0] delta,
		input logic [SB-1:0]        size
	);
		logic signed [WB-1:0] sum;
		logic signed [WB-1:0] lim;
		logic signed [WB-1:0] cmax;
		logic signed [WB-1:0] res;
		cmax = WB'({CB{1'b1}});
		lim  = (size == '0) ? '0 : $signed(WB'(size)) - WB'(1);
		if (lim > cmax) lim = cmax;
		sum = $signed(WB'(pos)) + delta;
		if (sum < 0) res = '0;
		else if (sum > lim) res = lim;
		else res = sum;
		return res[CB-1:0];
	endfunction

	assign advance   = in_valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = in_valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		logic [7:0] d;
		d         = in_data_s1.data_byte;
		pkt_pos_d = pkt_pos_q;
		header_d  = header_q;
		dx_d      = dx_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		buttons_d = buttons_q;
		status_d  = ps2mct_pkg::ST_IGNORED;
		if (in_data_s1.from_aux_port) begin
			unique case (pkt_pos_q)
				ps2mct_pkg::POS_HEADER: begin
					// resync: a header always has bit 3 set
					if (d[ps2mct_pkg::SYNC_BIT]) begin
						header_d  = d;
						pkt_pos_d = ps2mct_pkg::POS_DX;
						status_d  = ps2mct_pkg::ST_STORED;
					end
				end
				ps2mct_pkg::POS_DX: begin
					dx_d      = d;
					pkt_pos_d = ps2mct_pkg::POS_DY;
					status_d  = ps2mct_pkg::ST_STORED;
				end
				default: begin
					pkt_pos_d = ps2mct_pkg::POS_HEADER;
					if ((header_q & ps2mct_pkg::OVERFLOW_MASK) != 8'h00) begin
						status_d = ps2mct_pkg::ST_DISCARD;
					end else begin
						buttons_d = header_q[2:0];
						pos_x_d   = clamp_axis(pos_x_q,
							$signed({{(WB-8){dx_q[7]}}, dx_q}), width_q);
						// Y axis grows downward on screen
						pos_y_d   = clamp_axis(pos_y_q,
							-$signed({{(WB-8){d[7]}}, d}), height_q);
						status_d  = ps2mct_pkg::ST_APPLIED;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ps2mct_pkg::WIDTH_RESET;
			height_q <= ps2mct_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ps2mct_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				ps2mct_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pkt_pos_q   <= ps2mct_pkg::POS_HEADER;
			header_q    <= '0;
			dx_q        <= '0;
			pos_x_q     <= ps2mct_pkg::START_POS;
			pos_y_q     <= ps2mct_pkg::START_POS;
			buttons_q   <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				pkt_pos_q   <= pkt_pos_d;
				header_q    <= header_d;
				dx_q        <= dx_d;
				pos_x_q     <= pos_x_d;
				pos_y_q     <= pos_y_d;
				buttons_q   <= buttons_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.byte_status <= status_d;
			out_data_q.cursor_x    <= pos_x_d;
			out_data_q.cursor_y    <= pos_y_d;
			out_data_q.button_bits <= buttons_d;
		end
	end

endmodule

FILE: hdl/ps2mct_checker.sv
// Port-level checker for the PS/2 mouse packet cursor tracker, with its bind.
module ps2mct_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input ps2mct_pkg::out_req_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// input side backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without output back-pressure");

	// a back-to-back result that applies no packet leaves cursor and buttons alone
	a_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall ##1
		out_valid && out_data.byte_status != ps2mct_pkg::ST_APPLIED |->
		out_data.cursor_x == $past(out_data.cursor_x) &&
		out_data.cursor_y == $past(out_data.cursor_y) &&
		out_data.button_bits == $past(out_data.button_bits))
		else $error("cursor moved without an applied packet");

	// reset empties both sides
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("activity during reset");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker u_ps2mct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
